// File: rtl/core/local_map_box_slider_unit_defines.svh
// Assertion macros shared by the checker of the local map box slider.
`ifndef LOCAL_MAP_BOX_SLIDER_UNIT_DEFINES_SVH
`define LOCAL_MAP_BOX_SLIDER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lmbs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lmbs assertion failed");

`endif

// File: rtl/core/lmbs_pkg.sv
// Types and constants of the local map box slider.
package lmbs_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pose_t;

	typedef enum logic [1:0] {
		KIND_INIT = 2'd0,
		KIND_STAY = 2'd1,
		KIND_BOX  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
		logic               last;
	} result_t;

	typedef struct packed {
		pose_t pose;
		logic  first;
	} entry_t;

	typedef struct packed {
		logic [19:0] edge_len;
		logic [19:0] sense_range;
		logic [10:0] move_ratio;
	} cfg_t;

	typedef enum logic [1:0] {
		CFG_CUBE_LEN   = 2'd0,
		CFG_DET_RANGE  = 2'd1,
		CFG_MOVE_RATIO = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_DIST,
		ST_NEAR,
		ST_STAY,
		ST_RND,
		ST_MUL,
		ST_MOV,
		ST_EMIT
	} state_t;

	localparam logic [19:0] CUBE_LEN_RST   = 20'd1024000;
	localparam logic [19:0] DET_RANGE_RST  = 20'd102400;
	localparam logic [10:0] MOVE_RATIO_RST = 11'd384;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int TQ_W        = 31;
	localparam int TQ_SHIFT    = 8;
	localparam int AB_W        = 38;
	localparam int A_SCALE     = 2304;
	localparam int A_TQ_SCALE  = 18;
	localparam int B_TQ_SCALE  = 20;
	localparam int B_D_SCALE   = 5120;
	localparam int ROUND_HALF  = 2560;
	localparam int RND_SHIFT   = 10;
	localparam int MOV_W       = AB_W - RND_SHIFT;
	localparam int U_W         = 30;
	localparam logic [U_W-1:0] DIV_BIAS = 30'd335544320;
	localparam logic [U_W-1:0] RECIP5   = 30'd858993460;
	localparam int RECIP_SHIFT = 32;
	localparam logic [MOV_W-1:0] MOV_BIAS = 28'd67108864;

endpackage

// File: rtl/core/local_map_box_slider_unit.sv
// Top level of the local map box slider.
//
// The block keeps a local map cube around a moving lidar. Each transfer on the
// pose channel carries the lidar position in 1/1024 m units. The first pose
// after reset places the cube and yields one item of kind init. Each later
// pose yields one item of kind stay when no face is near, or one box item per
// axis that must shift, in x, y, z order, with last set on the final one.
// The cfg channel is always ready; the user is to write registers only while
// idle, which the block does not enforce. The back part works on one pose at
// a time: init places the cube; dist, near, stay keep it; dist, near, rnd,
// mul, mov, then emit once per box, shift it. A two-entry queue keeps the pose
// channel ready while the back part is busy, so that the first poses enter
// at once. Results sit in an output register; while the receiver stalls the
// back part holds its work and the queue fills, then pose_ready drops.
// Reset empties the queue and the output register, restores the register
// defaults and forgets the cube, so the next pose places it again.
module local_map_box_slider_unit #(
	parameter int COORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pose_valid,
	output logic                pose_ready,
	input  lmbs_pkg::pose_t     pose,
	output logic                result_valid,
	input  logic                result_ready,
	output lmbs_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [19:0]         cfg_data
);

	lmbs_pkg::cfg_t   cfg_q;
	lmbs_pkg::entry_t push_item;
	lmbs_pkg::entry_t head;
	logic             push;
	logic             full;
	logic             pop;
	logic             nempty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_len    <= lmbs_pkg::CUBE_LEN_RST;
			cfg_q.sense_range <= lmbs_pkg::DET_RANGE_RST;
			cfg_q.move_ratio  <= lmbs_pkg::MOVE_RATIO_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (lmbs_pkg::cfg_idx_t'(cfg_index))
				lmbs_pkg::CFG_CUBE_LEN:   cfg_q.edge_len    <= cfg_data;
				lmbs_pkg::CFG_DET_RANGE:  cfg_q.sense_range <= cfg_data;
				lmbs_pkg::CFG_MOVE_RATIO: cfg_q.move_ratio  <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	lmbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pose_valid (pose_valid),
		.pose_ready (pose_ready),
		.pose       (pose),
		.q_full     (full),
		.q_push     (push),
		.q_item     (push_item)
	);

	lmbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.nempty    (nempty),
		.head      (head)
	);

	lmbs_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_nempty     (nempty),
		.q_head       (head),
		.q_pop        (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: rtl/core/lmbs_front.sv
// Front part: takes pose transfers and tags the one that places the cube.
module lmbs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pose_valid,
	output logic                pose_ready,
	input  lmbs_pkg::pose_t     pose,
	input  logic                q_full,
	output logic                q_push,
	output lmbs_pkg::entry_t    q_item
);

	logic seen_q;

	assign pose_ready   = !q_full;
	assign q_push       = pose_valid && pose_ready;
	assign q_item.pose  = pose;
	assign q_item.first = !seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (q_push) begin
			seen_q <= 1'b1;
		end
	end

endmodule

// File: rtl/core/lmbs_queue.sv
// Short queue of tagged poses between the front and the back part.
module lmbs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lmbs_pkg::entry_t    push_item,
	output logic                full,
	input  logic                pop,
	output logic                nempty,
	output lmbs_pkg::entry_t    head
);

	localparam int QD = lmbs_pkg::QUEUE_DEPTH;
	localparam int PW = lmbs_pkg::QUEUE_PTR_W;
	localparam int CW = lmbs_pkg::QUEUE_CNT_W;

	lmbs_pkg::entry_t mem_q [QD];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full   = (count_q == CW'(QD));
	assign nempty = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/lmbs_back.sv
// Back part: keeps the cube, decides the shift and emits result items.
module lmbs_back #(
	parameter int COORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lmbs_pkg::cfg_t      cfg,
	input  logic                q_nempty,
	input  lmbs_pkg::entry_t    q_head,
	output logic                q_pop,
	output logic                result_valid,
	input  logic                result_ready,
	output lmbs_pkg::result_t   result
);

	localparam int C  = COORD_BITS;
	localparam int W  = ((C > 32) ? C : 32) + 2;
	localparam int AW = lmbs_pkg::AB_W;
	localparam int MW = lmbs_pkg::MOV_W;
	localparam int UW = lmbs_pkg::U_W;
	localparam int TW = lmbs_pkg::TQ_W;

	localparam logic signed [W-1:0] C_MAX = {{(W - C + 1){1'b0}}, {(C - 1){1'b1}}};
	localparam logic signed [W-1:0] C_MIN = {{(W - C + 1){1'b1}}, {(C - 1){1'b0}}};
	localparam logic signed [W-1:0] O_MAX = {{(W - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [W-1:0] O_MIN = {{(W - 31){1'b1}}, {31{1'b0}}};

	function automatic logic signed [C-1:0] sat_c(input logic signed [W-1:0] v);
		logic signed [C-1:0] r;
		if (v > C_MAX) begin
			r = C_MAX[C-1:0];
		end else if (v < C_MIN) begin
			r = C_MIN[C-1:0];
		end else begin
			r = v[C-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [W-1:0] ext_c(input logic signed [C-1:0] v);
		return {{(W - C){v[C-1]}}, v};
	endfunction

	function automatic logic signed [W-1:0] ext_p(input logic signed [31:0] v);
		return {{(W - 32){v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat_o(input logic signed [C-1:0] v);
		logic signed [W-1:0] e;
		logic signed [31:0]  r;
		e = ext_c(v);
		if (e > O_MAX) begin
			r = O_MAX[31:0];
		end else if (e < O_MIN) begin
			r = O_MIN[31:0];
		end else begin
			r = e[31:0];
		end
		return r;
	endfunction

	function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	lmbs_pkg::state_t    st_q, st_d;
	lmbs_pkg::pose_t     pos_q;
	logic signed [C-1:0] cube_min_q [3];
	logic signed [C-1:0] cube_max_q [3];
	logic signed [C-1:0] old_min_q [3];
	logic signed [C-1:0] old_max_q [3];
	logic signed [W-1:0] diff_lo_q [3];
	logic signed [W-1:0] diff_hi_q [3];
	logic [TW-1:0]       tq_q;
	logic [2:0]          near_lo_q;
	logic [2:0]          pend_q;
	logic [AW-1:0]       a_q;
	logic [AW-1:0]       b_q;
	logic [UW-1:0]       u_q;
	logic [2*UW-1:0]     prod_q;
	logic [MW-1:0]       mov_q;
	lmbs_pkg::result_t   res_q, res_d;
	logic                res_valid_q;
	logic                res_load;

	logic signed [31:0]  pos_a [3];
	logic signed [C-1:0] init_min [3];
	logic signed [C-1:0] init_max [3];
	logic [2:0]          near_lo_c;
	logic [2:0]          near_hi_c;
	logic [W-1:0]        thr;
	logic                slot_free;
	logic [1:0]          sel;
	logic [2:0]          pend_next;
	logic signed [W-1:0] half;
	logic signed [W-1:0] mov_w;
	logic signed [W-1:0] step;
	logic signed [C-1:0] new_min;
	logic signed [C-1:0] new_max;
	logic signed [31:0]  bmin [3];
	logic signed [31:0]  bmax [3];
	logic [AW-1:0]       a_d;
	logic [AW-1:0]       b_d;
	logic [AW-1:0]       mx;
	logic [AW-1:0]       rnd;
	logic [MW-1:0]       q_div;
	logic [UW-1:0]       u_d;

	assign pos_a[0] = pos_q.pos_x;
	assign pos_a[1] = pos_q.pos_y;
	assign pos_a[2] = pos_q.pos_z;

	assign slot_free    = !res_valid_q || result_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign half = {{(W - 19){1'b0}}, cfg.edge_len[19:1]};
	assign thr  = {{(W - TW + lmbs_pkg::TQ_SHIFT){1'b0}}, tq_q[TW-1:lmbs_pkg::TQ_SHIFT]};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			init_min[i]  = sat_c(ext_p(pos_a[i]) - half);
			init_max[i]  = sat_c(ext_p(pos_a[i]) + half);
			near_lo_c[i] = (abs_w(diff_lo_q[i]) <= thr);
			near_hi_c[i] = (abs_w(diff_hi_q[i]) <= thr);
		end
	end

	assign a_d = AW'(cfg.edge_len) * AW'(lmbs_pkg::A_SCALE)
		- AW'(tq_q) * AW'(lmbs_pkg::A_TQ_SCALE);
	assign b_d = AW'(tq_q) * AW'(lmbs_pkg::B_TQ_SCALE)
		- AW'(cfg.sense_range) * AW'(lmbs_pkg::B_D_SCALE);

	assign mx    = ($signed(a_q) > $signed(b_q)) ? a_q : b_q;
	assign rnd   = mx + AW'(lmbs_pkg::ROUND_HALF);
	assign q_div = rnd[AW-1:lmbs_pkg::RND_SHIFT];
	assign u_d   = {{(UW - MW){q_div[MW-1]}}, q_div} + lmbs_pkg::DIV_BIAS;

	// The lowest pending axis goes first, so boxes leave in x, y, z order.
	always_comb begin
		if (pend_q[0]) begin
			sel = 2'd0;
		end else if (pend_q[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
		pend_next = pend_q & ~(3'b001 << sel);
	end

	assign mov_w   = {{(W - MW){mov_q[MW-1]}}, mov_q};
	assign step    = near_lo_q[sel] ? -mov_w : mov_w;
	assign new_min = sat_c(ext_c(cube_min_q[sel]) + step);
	assign new_max = sat_c(ext_c(cube_max_q[sel]) + step);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bmin[i] = sat_o(old_min_q[i]);
			bmax[i] = sat_o(old_max_q[i]);
		end
		if (near_lo_q[sel]) begin
			bmin[sel] = sat_o(new_max);
		end else begin
			bmax[sel] = sat_o(new_min);
		end
	end

	always_comb begin
		st_d     = st_q;
		q_pop    = 1'b0;
		res_load = 1'b0;
		res_d    = '0;
		case (st_q)
			lmbs_pkg::ST_IDLE: begin
				if (q_nempty) begin
					q_pop = 1'b1;
					st_d  = q_head.first ? lmbs_pkg::ST_INIT : lmbs_pkg::ST_DIST;
				end
			end
			lmbs_pkg::ST_INIT: begin
				res_d.kind = lmbs_pkg::KIND_INIT;
				res_d.last = 1'b1;
				if (slot_free) begin
					res_load = 1'b1;
					st_d     = lmbs_pkg::ST_IDLE;
				end
			end
			lmbs_pkg::ST_DIST: begin
				st_d = lmbs_pkg::ST_NEAR;
			end
			lmbs_pkg::ST_NEAR: begin
				st_d = (|(near_lo_c | near_hi_c)) ? lmbs_pkg::ST_RND : lmbs_pkg::ST_STAY;
			end
			lmbs_pkg::ST_STAY: begin
				res_d.kind = lmbs_pkg::KIND_STAY;
				res_d.last = 1'b1;
				if (slot_free) begin
					res_load = 1'b1;
					st_d     = lmbs_pkg::ST_IDLE;
				end
			end
			lmbs_pkg::ST_RND: begin
				st_d = lmbs_pkg::ST_MUL;
			end
			lmbs_pkg::ST_MUL: begin
				st_d = lmbs_pkg::ST_MOV;
			end
			lmbs_pkg::ST_MOV: begin
				st_d = lmbs_pkg::ST_EMIT;
			end
			lmbs_pkg::ST_EMIT: begin
				res_d.kind      = lmbs_pkg::KIND_BOX;
				res_d.box_min_x = bmin[0];
				res_d.box_min_y = bmin[1];
				res_d.box_min_z = bmin[2];
				res_d.box_max_x = bmax[0];
				res_d.box_max_y = bmax[1];
				res_d.box_max_z = bmax[2];
				res_d.last      = (pend_next == 3'b000);
				if (slot_free) begin
					res_load = 1'b1;
					if (pend_next == 3'b000) begin
						st_d = lmbs_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				st_d = lmbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= lmbs_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		case (st_q)
			lmbs_pkg::ST_IDLE: begin
				if (q_pop) begin
					pos_q <= q_head.pose;
				end
			end
			lmbs_pkg::ST_INIT: begin
				if (res_load) begin
					for (int i = 0; i < 3; i++) begin
						cube_min_q[i] <= init_min[i];
						cube_max_q[i] <= init_max[i];
					end
				end
			end
			lmbs_pkg::ST_DIST: begin
				tq_q <= TW'(cfg.move_ratio) * TW'(cfg.sense_range);
				for (int i = 0; i < 3; i++) begin
					diff_lo_q[i] <= ext_p(pos_a[i]) - ext_c(cube_min_q[i]);
					diff_hi_q[i] <= ext_p(pos_a[i]) - ext_c(cube_max_q[i]);
				end
			end
			lmbs_pkg::ST_NEAR: begin
				near_lo_q <= near_lo_c;
				pend_q    <= near_lo_c | near_hi_c;
				a_q       <= a_d;
				b_q       <= b_d;
			end
			lmbs_pkg::ST_RND: begin
				u_q <= u_d;
			end
			lmbs_pkg::ST_MUL: begin
				prod_q <= (2 * UW)'(u_q) * (2 * UW)'(lmbs_pkg::RECIP5);
			end
			lmbs_pkg::ST_MOV: begin
				mov_q <= prod_q[lmbs_pkg::RECIP_SHIFT +: MW] - lmbs_pkg::MOV_BIAS;
				for (int i = 0; i < 3; i++) begin
					old_min_q[i] <= cube_min_q[i];
					old_max_q[i] <= cube_max_q[i];
				end
			end
			lmbs_pkg::ST_EMIT: begin
				if (res_load) begin
					cube_min_q[sel] <= new_min;
					cube_max_q[sel] <= new_max;
					pend_q          <= pend_next;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/lmbs_checker.sv
// Port checker of the local map box slider and its bind.
`include "local_map_box_slider_unit_defines.svh"

module lmbs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pose_valid,
	input logic              pose_ready,
	input logic              result_valid,
	input logic              result_ready,
	input lmbs_pkg::result_t result
);

	`LMBS_ASSERT_NEXT(a_pose_hold, clk, arst_n, pose_valid && !pose_ready, pose_valid)
	`LMBS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))
	`LMBS_ASSERT_SAME(a_status_zero, clk, arst_n, result_valid && result.kind != lmbs_pkg::KIND_BOX, result.box_min_x == 0 && result.box_min_y == 0 && result.box_min_z == 0 && result.box_max_x == 0 && result.box_max_y == 0 && result.box_max_z == 0)
	`LMBS_ASSERT_SAME(a_status_last, clk, arst_n, result_valid && (result.kind == lmbs_pkg::KIND_INIT || result.kind == lmbs_pkg::KIND_STAY), result.last)

endmodule

bind local_map_box_slider_unit lmbs_checker u_lmbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pose_valid   (pose_valid),
	.pose_ready   (pose_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
